@@ rtl/core/scba_pkg.sv @@
// ----------------------------------------------------------------------------
// scba_pkg: shared definitions for the size class block allocator
// Sizes of the heap and pool, payload types, result codes, register indexes
// and the command and status bundles between the controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scba_pkg;

  // Allocator geometry.
  localparam int MAX_CLASS_EXP   = 14;
  localparam int MIN_CLASS_EXP   = 3;
  localparam int HEADER_BYTES    = 2;
  localparam int NUM_HEAPS       = 4;
  localparam int NUM_SUPERBLOCKS = 16;
  localparam int STACK_DEPTH     = 4096;
  localparam int NUM_CLASSES     = MAX_CLASS_EXP - MIN_CLASS_EXP + 1;
  localparam int NUM_STACKS      = NUM_HEAPS * NUM_CLASSES;

  // Field and state widths.
  localparam int ADDR_W      = 18;
  localparam int HEAP_W      = 2;
  localparam int CLS_W       = 4;
  localparam int BYTES_W     = 16;
  localparam int TAG_W       = 8;
  localparam int NEED_W      = BYTES_W + 1;
  localparam int STACK_IDX_W = $clog2(NUM_STACKS);
  localparam int DEPTH_W     = $clog2(STACK_DEPTH);
  localparam int COUNT_W     = DEPTH_W + 1;
  localparam int CARVE_W     = MAX_CLASS_EXP - MIN_CLASS_EXP + 1;
  localparam int SB_W        = $clog2(NUM_SUPERBLOCKS);
  localparam int SB_CNT_W    = SB_W + 1;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int HEAPS_CFG_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAPS_IN_USE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPERBLOCKS_IN_USE = 2'd1;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    STAT_ALLOCATED   = 3'd0,
    STAT_FREED       = 3'd1,
    STAT_TOO_LARGE   = 3'd2,
    STAT_OUT_OF_MEM  = 3'd3,
    STAT_BAD_TAGS    = 3'd4,
    STAT_STACK_FULL  = 3'd5,
    STAT_BAD_HEAP    = 3'd6
  } status_e;

  typedef struct packed {
    action_e             action;
    logic [HEAP_W-1:0]   heap_select;
    logic [BYTES_W-1:0]  request_bytes;
    logic [ADDR_W-1:0]   free_address;
    logic [TAG_W-1:0]    owner_heap_tag;
    logic [TAG_W-1:0]    size_class_tag;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    logic [ADDR_W-1:0]   user_address;
    logic [HEAP_W-1:0]   header_heap;
    logic [CLS_W-1:0]    header_class;
  } out_item_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_LOOK,
    CS_POP
  } ctl_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic pop_load;
  } ctl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic need_pop;
  } ctl_status_t;

endpackage

`default_nettype wire

@@ rtl/core/scba_ctrl.sv @@
// ----------------------------------------------------------------------------
// scba_ctrl: allocator sequencer
// Takes one item, lets the datapath decide and commit once the output slot
// is free, and adds a pop step when a block comes off a free stack.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_ctrl
  import scba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ctl_status_t status_i,
  output ctl_cmd_t    cmd_o
);

  ctl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = CS_LOOK;
        end
      end
      CS_LOOK: begin
        // Side effects happen only when the result can be placed.
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = status_i.need_pop ? CS_POP : CS_IDLE;
        end
      end
      CS_POP: begin
        if (status_i.out_free) begin
          cmd_o.pop_load = 1'b1;
          state_d        = CS_IDLE;
        end
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // The pop wait is only entered from the lookup step.
  a_pop_after_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_POP) |-> ($past(state_q) == CS_LOOK) || ($past(state_q) == CS_POP))
    else $error("pop state entered without a lookup");
`endif

endmodule

`default_nettype wire

@@ rtl/core/scba_datapath.sv @@
// ----------------------------------------------------------------------------
// scba_datapath: allocator state, decode and result register
// Holds the configuration, the per-stack records, the free stack memory,
// the pool pointer and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module scba_datapath
  import scba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_item_t              in_item_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  ctl_cmd_t              cmd_i,
  output ctl_status_t           status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output out_item_t             out_item_o
);

  localparam int OFF_W   = CARVE_W + MAX_CLASS_EXP;
  localparam int FS_IDX_W = STACK_IDX_W + DEPTH_W;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [CARVE_W-1:0] remain;
    logic [SB_W-1:0]    sb;
  } stack_rec_t;

  // Smallest class that holds the request plus its header.
  function automatic logic [CLS_W-1:0] class_of(input logic [NEED_W-1:0] need);
    logic [CLS_W-1:0] e;
    e = CLS_W'(MAX_CLASS_EXP);
    for (int k = MAX_CLASS_EXP - 1; k >= MIN_CLASS_EXP; k--) begin
      if (need <= (NEED_W'(1) << k)) begin
        e = CLS_W'(k);
      end
    end
    return e;
  endfunction

  // Configuration registers.
  logic [HEAPS_CFG_W-1:0] heaps_q;
  logic [SB_CNT_W-1:0]    sbs_q;
  logic [HEAPS_CFG_W-1:0] heap_lim;
  logic [SB_CNT_W-1:0]    sb_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heaps_q <= HEAPS_CFG_W'(NUM_HEAPS);
      sbs_q   <= SB_CNT_W'(NUM_SUPERBLOCKS);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_HEAPS_IN_USE:       heaps_q <= cfg_data_i[HEAPS_CFG_W-1:0];
        CFG_SUPERBLOCKS_IN_USE: sbs_q   <= cfg_data_i[SB_CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign heap_lim = (heaps_q > HEAPS_CFG_W'(NUM_HEAPS)) ? HEAPS_CFG_W'(NUM_HEAPS) : heaps_q;
  assign sb_lim   = (sbs_q > SB_CNT_W'(NUM_SUPERBLOCKS)) ? SB_CNT_W'(NUM_SUPERBLOCKS) : sbs_q;

  // Decode of the incoming item.
  logic [NEED_W-1:0]      need;
  logic                   too_large_d, bad_heap_d, bad_tags_d;
  logic [HEAP_W-1:0]      heap_d;
  logic [CLS_W-1:0]       cls_d;
  logic [STACK_IDX_W-1:0] sidx_d;

  always_comb begin
    need        = NEED_W'(in_item_i.request_bytes) + NEED_W'(HEADER_BYTES);
    too_large_d = need > (NEED_W'(1) << MAX_CLASS_EXP);
    bad_heap_d  = {1'b0, in_item_i.heap_select} >= heap_lim;
    bad_tags_d  = (in_item_i.owner_heap_tag >= TAG_W'(heap_lim))
               || (in_item_i.size_class_tag < TAG_W'(MIN_CLASS_EXP))
               || (in_item_i.size_class_tag > TAG_W'(MAX_CLASS_EXP))
               || (in_item_i.free_address < ADDR_W'(HEADER_BYTES));
    if (in_item_i.action == ACT_FREE) begin
      heap_d = in_item_i.owner_heap_tag[HEAP_W-1:0];
      cls_d  = in_item_i.size_class_tag[CLS_W-1:0];
    end else begin
      heap_d = in_item_i.heap_select;
      cls_d  = class_of(need);
    end
    sidx_d = STACK_IDX_W'(heap_d) * STACK_IDX_W'(NUM_CLASSES)
           + STACK_IDX_W'(cls_d) - STACK_IDX_W'(MIN_CLASS_EXP);
  end

  // Registered item and decode.
  in_item_t               item_q;
  logic                   too_large_q, bad_heap_q, bad_tags_q;
  logic [HEAP_W-1:0]      heap_q;
  logic [CLS_W-1:0]       cls_q;
  logic [STACK_IDX_W-1:0] sidx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q      <= in_item_i;
      too_large_q <= too_large_d;
      bad_heap_q  <= bad_heap_d;
      bad_tags_q  <= bad_tags_d;
      heap_q      <= heap_d;
      cls_q       <= cls_d;
      sidx_q      <= sidx_d;
    end
  end

  // Per-stack record memory; a record never written reads as zero.
  stack_rec_t              rec_mem [NUM_STACKS];
  stack_rec_t              rec_rd_q, rec, rec_wdata;
  logic [NUM_STACKS-1:0]   rec_valid_q;
  logic                    rec_hit_q;
  logic                    rec_we;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rec_rd_q  <= rec_mem[sidx_d];
      rec_hit_q <= rec_valid_q[sidx_d];
    end
    if (rec_we) begin
      rec_mem[sidx_q] <= rec_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_valid_q <= '0;
    end else if (rec_we) begin
      rec_valid_q[sidx_q] <= 1'b1;
    end
  end

  assign rec = rec_hit_q ? rec_rd_q : '0;

  // Pool pointer.
  logic [SB_CNT_W-1:0] nsb_q;

  // Decision for the registered item.
  logic                   is_free, stack_empty, carve_empty, pool_empty, stack_full;
  logic                   alloc_ok, do_pop, do_carve, do_claim, do_push;
  logic [SB_W-1:0]        sb_use;
  logic [CARVE_W-1:0]     rem_base, rem_new;
  logic [OFF_W-1:0]       off_wide;
  logic [ADDR_W-1:0]      carve_start;
  logic [COUNT_W-1:0]     cnt_m1;
  out_item_t              res;

  always_comb begin
    is_free     = item_q.action == ACT_FREE;
    stack_empty = rec.count == '0;
    carve_empty = rec.remain == '0;
    pool_empty  = nsb_q >= sb_lim;
    stack_full  = rec.count >= COUNT_W'(STACK_DEPTH);
    alloc_ok    = !is_free && !too_large_q && !bad_heap_q;
    do_pop      = alloc_ok && !stack_empty;
    do_carve    = alloc_ok && stack_empty && !(carve_empty && pool_empty);
    do_claim    = do_carve && carve_empty;
    do_push     = is_free && !bad_tags_q && !stack_full;
    cnt_m1      = rec.count - COUNT_W'(1);

    // Carving runs from the top of the superblock down.
    sb_use      = carve_empty ? nsb_q[SB_W-1:0] : rec.sb;
    rem_base    = carve_empty ? (CARVE_W'(1) << (CLS_W'(MAX_CLASS_EXP) - cls_q)) : rec.remain;
    rem_new     = rem_base - CARVE_W'(1);
    off_wide    = OFF_W'(rem_new) << cls_q;
    carve_start = {sb_use, off_wide[MAX_CLASS_EXP-1:0]};

    // Record update.
    rec_wdata = rec;
    if (do_pop) begin
      rec_wdata.count = cnt_m1;
    end else if (do_push) begin
      rec_wdata.count = rec.count + COUNT_W'(1);
    end else begin
      rec_wdata.remain = rem_new;
      rec_wdata.sb     = sb_use;
    end
    rec_we = cmd_i.commit && (do_pop || do_push || do_carve);

    // Immediate result; a pop delivers its result later, through the pop state.
    res = '{status: STAT_ALLOCATED, user_address: '0, header_heap: '0, header_class: '0};
    if (!is_free) begin
      if (too_large_q) begin
        res.status = STAT_TOO_LARGE;
      end else if (bad_heap_q) begin
        res.status = STAT_BAD_HEAP;
      end else if (!do_carve) begin
        res.status = STAT_OUT_OF_MEM;
      end else begin
        res.user_address = carve_start + ADDR_W'(HEADER_BYTES);
        res.header_heap  = heap_q;
        res.header_class = cls_q;
      end
    end else begin
      if (bad_tags_q) begin
        res.status = STAT_BAD_TAGS;
      end else if (stack_full) begin
        res.status = STAT_STACK_FULL;
      end else begin
        res.status = STAT_FREED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nsb_q <= '0;
    end else if (cmd_i.commit && do_claim) begin
      nsb_q <= nsb_q + SB_CNT_W'(1);
    end
  end

  // Free stack memory, addressed by stack and slot.
  logic [ADDR_W-1:0]   fs_mem [NUM_STACKS * STACK_DEPTH];
  logic [ADDR_W-1:0]   fs_rd_q;
  logic [FS_IDX_W-1:0] fs_waddr, fs_raddr;

  assign fs_waddr = {sidx_q, rec.count[DEPTH_W-1:0]};
  assign fs_raddr = {sidx_q, cnt_m1[DEPTH_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_push) begin
      fs_mem[fs_waddr] <= item_q.free_address - ADDR_W'(HEADER_BYTES);
    end
    if (cmd_i.commit && do_pop) begin
      fs_rd_q <= fs_mem[fs_raddr];
    end
  end

  // Output register.
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      load_direct, out_load;

  assign load_direct = cmd_i.commit && !do_pop;
  assign out_load    = load_direct || cmd_i.pop_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_direct) begin
      out_item_q <= res;
    end else if (cmd_i.pop_load) begin
      out_item_q <= '{status:       STAT_ALLOCATED,
                      user_address: fs_rd_q + ADDR_W'(HEADER_BYTES),
                      header_heap:  heap_q,
                      header_class: cls_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_item_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.need_pop = do_pop;

`ifndef SYNTHESIS
  // The pool pointer never passes the end of the pool.
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nsb_q <= SB_CNT_W'(NUM_SUPERBLOCKS))
    else $error("pool pointer beyond the pool");

  // A result appears only after a commit or a pop load.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit || cmd_i.pop_load))
    else $error("result without a commit");

  // Every allocated block sits past its header and has a class no smaller than the smallest class.
  a_alloc_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_item_q.status == STAT_ALLOCATED) |->
      (out_item_q.user_address >= ADDR_W'(HEADER_BYTES))
      && (out_item_q.header_class >= CLS_W'(MIN_CLASS_EXP)))
    else $error("allocated block with bad address or class");
`endif

endmodule

`default_nettype wire

@@ rtl/core/size_class_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// size_class_block_allocator_top: segregated power-of-two block allocator
// Serves allocations and frees from per-heap, per-class LIFO free stacks
// backed by a pool of superblocks carved from the top down.
// ----------------------------------------------------------------------------
// Each accepted item yields exactly one result. The per-class record
// memory is read into a register when an item is accepted, and the lookup
// step decides and updates the records. An allocation served from a free
// stack adds a pop step, since the free stack memory read is registered.
// A stalled output slot lengthens the lookup step until the result
// register can be loaded; a new item is accepted while a finished result
// still waits. Per-class records clear at reset through valid bits, so no
// clearing pass is needed. The user must write configuration only while
// idle; the block does not enforce it. The config channel is always ready.
`default_nettype none

module size_class_block_allocator_top
  import scba_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  ctl_cmd_t    cmd;
  ctl_status_t status;

  assign cfg_ready_o = 1'b1;

  scba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  scba_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
